// ----- rtl/skm_pkg.sv -----
// Package for the stream keyword masker.
// Holds the size constants, the register indexes and the beat payload types.
// Depends on nothing.
`default_nettype none

package skm_pkg;

   localparam int MAX_KEYWORD_LEN = 8;
   localparam int KEYWORD_W       = 64;
   localparam int LEN_W           = 4;
   localparam int CSR_INDEX_W     = 2;
   localparam int COUNT_W         = $clog2(MAX_KEYWORD_LEN + 1);
   localparam int IDX_W           = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;

   localparam logic [7:0] ASTERISK = 8'h2A;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEYWORD_BYTES  = 2'd0,
      CSR_KEYWORD_LENGTH = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ----- rtl/stream_keyword_masker.sv -----
// Top level of the stream keyword masker: window, match logic and output register.
// Depends on skm_pkg for constants and payload types.
//
//   channel  direction  payload            purpose
//   req_     in         req_payload_type   text bytes, end_of_text marks the last
//   rsp_     out        rsp_payload_type   bytes with keyword matches as asterisks
//   csr_     in         index + 64 bits    keyword bytes and keyword length
//
// With a fixed keyword and rsp_ready high, one byte enters and one leaves per cycle;
// a result appears in the cycle after its emission is decided by the window compare.
// A step that releases several beats (end of text, or a shorter keyword) sends them one at a
// time; input waits during an end-of-text flush, else only while a full window emits nothing.
// Reset is synchronous and empties the window; it needs no clearing pass.
// A stall on rsp_ready holds the output register and, with a full window, req_ready.
`default_nettype none

module stream_keyword_masker import skm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [KEYWORD_W-1:0]   csr_data
);

   logic [KEYWORD_W-1:0] kw_bytes_ff, kw_bytes_in;
   logic [LEN_W-1:0]     kw_len_ff, kw_len_in;
   logic [7:0]           window_ff [MAX_KEYWORD_LEN];
   logic [7:0]           window_in [MAX_KEYWORD_LEN];
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   mask_ff, mask_in;
   logic                 flush_ff, flush_in;
   logic                 active_ff, active_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   logic [COUNT_W-1:0]   len_eff, threshold, mask_cur, mask_load, mask_dec, wr_pos;
   logic [MAX_KEYWORD_LEN-1:0] hit;
   logic                 match, last, emit_need, emit_fire, accept;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (kw_len_ff > LEN_W'(MAX_KEYWORD_LEN)) begin
         len_eff = COUNT_W'(MAX_KEYWORD_LEN);
      end else begin
         len_eff = COUNT_W'(kw_len_ff);
      end
      threshold = (len_eff == '0) ? COUNT_W'(1) : len_eff;
      mask_cur  = (len_eff == '0) ? '0 : mask_ff;
      for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
         hit[i] = (COUNT_W'(i) >= len_eff) || (window_ff[i] == kw_bytes_ff[8*i +: 8]);
      end
      match     = (len_eff != '0) && (mask_cur == '0) && (count_ff >= len_eff) && (&hit);
      mask_load = match ? len_eff : mask_cur;
      mask_dec  = (mask_load != '0) ? mask_load - COUNT_W'(1) : '0;
      last      = flush_ff && (count_ff == COUNT_W'(1));
      emit_need = active_ff && (count_ff != '0) && ((count_ff >= threshold) || flush_ff);
      emit_fire = emit_need && (!rsp_valid_ff || rsp_ready);
      req_ready = !flush_ff && ((count_ff < COUNT_W'(MAX_KEYWORD_LEN)) || emit_fire);
      accept    = req_valid && req_ready;
   end

   always_comb begin
      kw_bytes_in = kw_bytes_ff;
      kw_len_in   = kw_len_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_KEYWORD_BYTES:  kw_bytes_in = csr_data;
            CSR_KEYWORD_LENGTH: kw_len_in   = csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      window_in = window_ff;
      if (emit_fire) begin
         for (int i = 0; i < MAX_KEYWORD_LEN - 1; i++) begin
            window_in[i] = window_ff[i+1];
         end
      end
      wr_pos = count_ff - (emit_fire ? COUNT_W'(1) : COUNT_W'(0));
      if (accept) begin
         window_in[wr_pos[IDX_W-1:0]] = req_data.in_byte;
      end

      count_in = count_ff + (accept ? COUNT_W'(1) : COUNT_W'(0))
                          - (emit_fire ? COUNT_W'(1) : COUNT_W'(0));

      mask_in = mask_ff;
      if (emit_fire) begin
         mask_in = mask_dec;
      end
      if (accept && (len_eff == '0)) begin
         mask_in = '0;
      end

      flush_in = flush_ff;
      if (accept && req_data.end_of_text) begin
         flush_in = 1'b1;
      end
      if (emit_fire && last) begin
         flush_in = 1'b0;
         mask_in  = '0;
         count_in = '0;
      end

      active_in = accept || (active_ff && emit_need);

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit_fire) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.out_byte  = (mask_load != '0) ? ASTERISK : window_ff[0];
         rsp_data_in.last_byte = last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kw_bytes_ff  <= '0;
         kw_len_ff    <= '0;
         count_ff     <= '0;
         mask_ff      <= '0;
         flush_ff     <= 1'b0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kw_bytes_ff  <= kw_bytes_in;
         kw_len_ff    <= kw_len_in;
         count_ff     <= count_in;
         mask_ff      <= mask_in;
         flush_ff     <= flush_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff   <= window_in;
      rsp_data_ff <= rsp_data_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_KEYWORD_LEN))
      else $error("window holds more bytes than its depth");

   assert property (@(posedge clock) disable iff (reset)
      mask_ff < COUNT_W'(MAX_KEYWORD_LEN))
      else $error("mask count beyond the longest keyword");

   assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> !req_ready)
      else $error("input taken while the text is being flushed");

   assert property (@(posedge clock) disable iff (reset)
      (emit_fire && last) |=> (count_ff == '0) && !flush_ff && rsp_valid && rsp_data.last_byte)
      else $error("final beat of a text did not leave the window empty");

endmodule

`default_nettype wire
